FILE: sv/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// shared widths, lane count and the saturating helper of the 3x3 inverse unit
// ----------------------------------------------------------------------------
`default_nettype none
package mi3_pkg;

  localparam int QW             = 32;
  localparam int MAG_W          = 64;
  localparam int DET_W          = 98;
  localparam int NLANE          = 9;
  localparam int QSTEPS         = 32;
  localparam int DIV_LAT        = QSTEPS + 2;
  localparam int DEF_FRAC_BITS  = 16;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [QW-1:0]    q_t;

  // sign and magnitude to a saturated 32-bit two's complement value
  function automatic q_t sat_q(input logic neg, input logic big, input logic [QW:0] m);
    q_t res;
    if (neg) begin
      if (big || (m > {1'b0, 1'b1, {(QW-1){1'b0}}})) begin
        res = {1'b1, {(QW-1){1'b0}}};
      end else begin
        res = q_t'(~m[QW-1:0] + 1'b1);
      end
    end else begin
      if (big || (m > {2'b00, {(QW-1){1'b1}}})) begin
        res = {1'b0, {(QW-1){1'b1}}};
      end else begin
        res = m[QW-1:0];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: sv/matrix3x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// 3x3 Q16.16 inverse by the adjugate with exact determinant and rounding
// ----------------------------------------------------------------------------
// throughput: one request per cycle outside reset, set by the fully pipelined cofactor,
//   determinant and 32-step divider datapath
// busy is high only while rst_n is low; reset empties the pipeline
// the receiver cannot stall, so nothing ever holds the pipeline
`default_nettype none
module matrix3x3_inverse_unit import mi3_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_a00,
  input  wire logic [31:0] in_a01,
  input  wire logic [31:0] in_a02,
  input  wire logic [31:0] in_a10,
  input  wire logic [31:0] in_a11,
  input  wire logic [31:0] in_a12,
  input  wire logic [31:0] in_a20,
  input  wire logic [31:0] in_a21,
  input  wire logic [31:0] in_a22,
  output logic             out_strobe,
  output logic [31:0]      out_b00,
  output logic [31:0]      out_b01,
  output logic [31:0]      out_b02,
  output logic [31:0]      out_b10,
  output logic [31:0]      out_b11,
  output logic [31:0]      out_b12,
  output logic [31:0]      out_b20,
  output logic [31:0]      out_b21,
  output logic [31:0]      out_b22,
  output logic [31:0]      out_determinant,
  output logic             out_singular
);

  localparam int LATENCY = 7 + DIV_LAT + 1;
  localparam int TERM_W  = QW + MAG_W;

  typedef struct packed {
    logic valid;
    logic sing;
    q_t   detq;
  } side_t;

  logic [6:0]               v_r;
  logic signed [QW-1:0]     a_r    [NLANE];
  logic signed [QW-1:0]     r0_2_r [3];
  logic signed [QW-1:0]     r0_3_r [3];
  logic signed [2*QW-1:0]   pa_r   [NLANE];
  logic signed [2*QW-1:0]   pb_r   [NLANE];
  logic signed [MAG_W-1:0]  cof_r  [NLANE];
  logic signed [2*QW:0]     plo_r  [3];
  logic signed [MAG_W-1:0]  phi_r  [3];
  mag_t                     cmag4_r [NLANE];
  mag_t                     cmag5_r [NLANE];
  mag_t                     cmag6_r [NLANE];
  mag_t                     cmag7_r [NLANE];
  logic [NLANE-1:0]         cs4_r, cs5_r, cs6_r, neg7_r;
  logic signed [TERM_W-1:0] term_r [3];
  logic signed [DET_W-1:0]  det_r;
  logic [DET_W-1:0]         dmag_r;
  logic                     dneg_r;
  logic                     sing_r;
  side_t                    side_r [DIV_LAT];
  side_t                    side_nxt;
  q_t                       divq   [NLANE];
  mag_t                     cmag_nxt [NLANE];
  logic [NLANE-1:0]         neg_nxt;
  logic [DET_W-1:0]         dmag_nxt;
  logic                     dneg_nxt;

  logic                     out_strobe_r, out_singular_r;
  q_t                       out_b_r [NLANE];
  q_t                       out_det_r;

  assign busy = !rst_n;

  always_comb begin
    logic [DET_W:0]           rnd;
    logic [DET_W-2*FRAC_BITS:0] sh;
    rnd      = {1'b0, dmag_r} + ((DET_W+1)'(1) << (2 * FRAC_BITS - 1));
    sh       = rnd[DET_W:2*FRAC_BITS];
    side_nxt.valid = v_r[6];
    side_nxt.sing  = sing_r;
    side_nxt.detq  = sat_q(dneg_r, |sh[DET_W-2*FRAC_BITS:QW+1], sh[QW:0]);
    dneg_nxt = det_r[DET_W-1];
    dmag_nxt = dneg_nxt ? DET_W'(-det_r) : DET_W'(det_r);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        neg_nxt[i*3+j]  = cs6_r[j*3+i] ^ dneg_nxt;
        cmag_nxt[i*3+j] = cmag6_r[j*3+i];
      end
    end
  end

  always_ff @(posedge clk) begin
    int r0, r1, c0, c1;
    if (!rst_n) begin
      v_r          <= '0;
      out_strobe_r <= 1'b0;
      for (int s = 0; s < DIV_LAT; s++) begin
        side_r[s].valid <= 1'b0;
      end
    end else begin
      v_r          <= {v_r[5:0], start};
      side_r[0].valid <= side_nxt.valid;
      for (int s = 1; s < DIV_LAT; s++) begin
        side_r[s].valid <= side_r[s-1].valid;
      end
      out_strobe_r <= side_r[DIV_LAT-1].valid;
    end

    a_r[0] <= in_a00; a_r[1] <= in_a01; a_r[2] <= in_a02;
    a_r[3] <= in_a10; a_r[4] <= in_a11; a_r[5] <= in_a12;
    a_r[6] <= in_a20; a_r[7] <= in_a21; a_r[8] <= in_a22;

    for (int i = 0; i < 3; i++) begin
      r0 = (i == 0) ? 1 : 0;
      r1 = (i == 2) ? 1 : 2;
      for (int j = 0; j < 3; j++) begin
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        pa_r[i*3+j] <= a_r[r0*3+c0] * a_r[r1*3+c1];
        pb_r[i*3+j] <= a_r[r0*3+c1] * a_r[r1*3+c0];
        cof_r[i*3+j] <= ((i + j) % 2 == 1) ? pb_r[i*3+j] - pa_r[i*3+j]
                                           : pa_r[i*3+j] - pb_r[i*3+j];
      end
    end

    for (int j = 0; j < 3; j++) begin
      r0_2_r[j] <= a_r[j];
      r0_3_r[j] <= r0_2_r[j];
      plo_r[j]  <= r0_3_r[j] * $signed({1'b0, cof_r[j][QW-1:0]});
      phi_r[j]  <= r0_3_r[j] * $signed(cof_r[j][MAG_W-1:QW]);
      term_r[j] <= (TERM_W'(phi_r[j]) <<< QW) + TERM_W'(plo_r[j]);
    end

    for (int l = 0; l < NLANE; l++) begin
      cmag4_r[l] <= cof_r[l][MAG_W-1] ? mag_t'(-cof_r[l]) : mag_t'(cof_r[l]);
      cmag5_r[l] <= cmag4_r[l];
      cmag6_r[l] <= cmag5_r[l];
      cmag7_r[l] <= cmag_nxt[l];
      cs4_r[l]   <= cof_r[l][MAG_W-1];
    end
    cs5_r  <= cs4_r;
    cs6_r  <= cs5_r;
    neg7_r <= neg_nxt;

    det_r  <= DET_W'(term_r[0]) + DET_W'(term_r[1]) + DET_W'(term_r[2]);
    dmag_r <= dmag_nxt;
    dneg_r <= dneg_nxt;
    sing_r <= (det_r == '0);

    side_r[0].sing <= side_nxt.sing;
    side_r[0].detq <= side_nxt.detq;
    for (int s = 1; s < DIV_LAT; s++) begin
      side_r[s].sing <= side_r[s-1].sing;
      side_r[s].detq <= side_r[s-1].detq;
    end

    out_singular_r <= side_r[DIV_LAT-1].sing;
    out_det_r      <= side_r[DIV_LAT-1].sing ? '0 : side_r[DIV_LAT-1].detq;
    for (int l = 0; l < NLANE; l++) begin
      out_b_r[l] <= side_r[DIV_LAT-1].sing ? '0 : divq[l];
    end
  end

  mi3_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .mag  (cmag7_r),
    .neg  (neg7_r),
    .dmag (dmag_r),
    .q    (divq)
  );

  assign out_strobe      = out_strobe_r;
  assign out_singular    = out_singular_r;
  assign out_determinant = out_det_r;
  assign out_b00 = out_b_r[0];
  assign out_b01 = out_b_r[1];
  assign out_b02 = out_b_r[2];
  assign out_b10 = out_b_r[3];
  assign out_b11 = out_b_r[4];
  assign out_b12 = out_b_r[5];
  assign out_b20 = out_b_r[6];
  assign out_b21 = out_b_r[7];
  assign out_b22 = out_b_r[8];

  // every accepted request strobes exactly once at the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("accepted request produced no result");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  // a singular result carries zero elements and zero determinant
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_singular) |->
      (out_determinant == '0 && out_b00 == '0 && out_b11 == '0 && out_b22 == '0))
    else $error("singular result with nonzero fields");

endmodule
`default_nettype wire

FILE: sv/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// nine pipelined restoring dividers sharing one divisor, rounded and saturated
// ----------------------------------------------------------------------------
`default_nettype none
module mi3_div import mi3_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic             clk,
  input  wire mag_t             mag [NLANE],
  input  wire logic [NLANE-1:0] neg,
  input  wire logic [DET_W-1:0] dmag,
  output q_t                    q [NLANE]
);

  localparam int NUM_W = MAG_W + 2 * FRAC_BITS;

  logic [DET_W-1:0]  d_r   [QSTEPS+1];
  logic [DET_W-1:0]  rem_r [NLANE][QSTEPS+1];
  logic [QSTEPS-1:0] lo_r  [NLANE][QSTEPS+1];
  logic [QSTEPS-1:0] quo_r [NLANE][QSTEPS+1];
  logic              ovf_r [NLANE][QSTEPS+1];
  logic              neg_r [NLANE][QSTEPS+1];
  q_t                q_r   [NLANE];

  logic [DET_W-1:0]  rem_nxt [NLANE][QSTEPS+1];
  logic [QSTEPS-1:0] lo_nxt  [NLANE];
  logic              ovf_nxt [NLANE];
  logic              qbit    [NLANE][QSTEPS+1];
  logic [QW:0]       qf      [NLANE];

  always_comb begin
    logic [NUM_W-1:0] num;
    logic [DET_W:0]   trial;
    for (int l = 0; l < NLANE; l++) begin
      num           = NUM_W'(mag[l]) << (2 * FRAC_BITS);
      lo_nxt[l]     = num[QSTEPS-1:0];
      ovf_nxt[l]    = DET_W'(num[NUM_W-1:QSTEPS]) >= dmag;
      rem_nxt[l][0] = DET_W'(num[NUM_W-1:QSTEPS]);
      qbit[l][0]    = 1'b0;
      for (int k = 1; k <= QSTEPS; k++) begin
        trial = {rem_r[l][k-1], lo_r[l][k-1][QSTEPS-1]};
        if (trial >= {1'b0, d_r[k-1]}) begin
          qbit[l][k]    = 1'b1;
          rem_nxt[l][k] = DET_W'(trial - {1'b0, d_r[k-1]});
        end else begin
          qbit[l][k]    = 1'b0;
          rem_nxt[l][k] = trial[DET_W-1:0];
        end
      end
      qf[l] = {1'b0, quo_r[l][QSTEPS]} +
              (QW+1)'({rem_r[l][QSTEPS], 1'b0} >= {1'b0, d_r[QSTEPS]});
    end
  end

  always_ff @(posedge clk) begin
    d_r[0] <= dmag;
    for (int k = 1; k <= QSTEPS; k++) begin
      d_r[k] <= d_r[k-1];
    end
    for (int l = 0; l < NLANE; l++) begin
      rem_r[l][0] <= rem_nxt[l][0];
      lo_r[l][0]  <= lo_nxt[l];
      quo_r[l][0] <= '0;
      ovf_r[l][0] <= ovf_nxt[l];
      neg_r[l][0] <= neg[l];
      for (int k = 1; k <= QSTEPS; k++) begin
        rem_r[l][k] <= rem_nxt[l][k];
        lo_r[l][k]  <= {lo_r[l][k-1][QSTEPS-2:0], 1'b0};
        quo_r[l][k] <= {quo_r[l][k-1][QSTEPS-2:0], qbit[l][k]};
        ovf_r[l][k] <= ovf_r[l][k-1];
        neg_r[l][k] <= neg_r[l][k-1];
      end
      q_r[l] <= sat_q(neg_r[l][QSTEPS], ovf_r[l][QSTEPS], qf[l]);
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire
